// ===== rtl/core/rnta_pkg.sv =====
// ----------------------------------------------------------------------------
// rnta_pkg
// Shared types, constants and helpers of the radix number to ASCII converter.
// ----------------------------------------------------------------------------
package rnta_pkg;

	localparam int VALUE_WIDTH        = 64;
	localparam int DIGIT_BUFFER_DEPTH = 24;
	localparam int QUEUE_DEPTH        = 2;

	localparam int RADIX_W = 6;
	localparam int PAD_W   = 6;
	localparam int PART_W  = RADIX_W + 1;
	localparam int STEP_W  = $clog2(VALUE_WIDTH);
	localparam int CNT_W   = $clog2(DIGIT_BUFFER_DEPTH + 1);
	localparam int IDX_W   = $clog2(DIGIT_BUFFER_DEPTH);
	localparam int PADC_W  = (CNT_W > PAD_W) ? CNT_W : PAD_W;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(8);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
	localparam logic [PAD_W-1:0]   PAD_MAX   = PAD_W'(32);
	localparam logic [7:0]         CHAR_ZERO = 8'h30;
	localparam logic [7:0]         CHAR_A    = 8'h61;
	localparam logic [7:0]         CHAR_NINE = 8'h39;
	localparam logic [7:0]         CHAR_Z    = 8'h7a;

	typedef struct packed {
		logic [63:0]        value;
		logic [RADIX_W-1:0] base;
		logic [PAD_W-1:0]   pad_width;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_beat_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [RADIX_W-1:0]     radix;
		logic [PAD_W-1:0]       pad;
	} job_t;

	function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [7:0] d8;
		d8 = 8'(d);
		if (d < RADIX_W'(10)) begin
			return CHAR_ZERO + d8;
		end
		return CHAR_A + (d8 - 8'd10);
	endfunction

endpackage

// ===== rtl/core/rnta_front.sv =====
// ----------------------------------------------------------------------------
// rnta_front
// Accepts input beats, clamps radix and pad width, trims the value.
// ----------------------------------------------------------------------------
module rnta_front import rnta_pkg::*; (
	input  logic     push,
	input  in_beat_t item,
	input  logic     q_full,
	output logic     full,
	output logic     q_push,
	output job_t     job
);

	always_comb begin
		job.value = item.value[VALUE_WIDTH-1:0];
		if (item.base < RADIX_MIN) begin
			job.radix = RADIX_MIN;
		end else if (item.base > RADIX_MAX) begin
			job.radix = RADIX_MAX;
		end else begin
			job.radix = item.base;
		end
		job.pad = (item.pad_width > PAD_MAX) ? PAD_MAX : item.pad_width;
	end

	assign full   = q_full;
	assign q_push = push && !q_full;

endmodule

// ===== rtl/core/rnta_queue.sv =====
// ----------------------------------------------------------------------------
// rnta_queue
// Short job queue between the front and the conversion engine.
// ----------------------------------------------------------------------------
module rnta_queue import rnta_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_push,
	input  job_t job_in,
	output logic q_full,
	output logic q_valid,
	input  logic q_pop,
	output job_t job_out
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign job_out = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (q_push) begin
			slot_q[wptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (q_push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (q_pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (q_push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !q_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/rnta_back.sv =====
// ----------------------------------------------------------------------------
// rnta_back
// Bit-serial restoring divider, digit buffer and character emitter.
// ----------------------------------------------------------------------------
module rnta_back import rnta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_t      job,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output out_beat_t result
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [RADIX_W-1:0]     part_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [PAD_W-1:0]       pad_q;
	logic [STEP_W-1:0]      step_q;
	logic [CNT_W-1:0]       ndig_q;
	logic [PADC_W-1:0]      pad_left_q;
	logic [RADIX_W-1:0]     digit_q [DIGIT_BUFFER_DEPTH];
	logic                   out_valid_q;
	out_beat_t              out_q;

	logic [PART_W-1:0]      trial;
	logic                   qbit;
	logic [RADIX_W-1:0]     part_next;
	logic [VALUE_WIDTH-1:0] quot_next;
	logic [CNT_W-1:0]       ndig_next;
	logic [PADC_W-1:0]      pad_ext;
	logic [PADC_W-1:0]      ndig_ext;
	logic [CNT_W-1:0]       rd_cnt;
	logic [IDX_W-1:0]       rd_idx;
	logic                   load;

	assign trial     = {part_q, div_q[VALUE_WIDTH-1]};
	assign qbit      = (trial >= {1'b0, radix_q});
	assign part_next = qbit ? RADIX_W'(trial - {1'b0, radix_q}) : RADIX_W'(trial);
	assign quot_next = {div_q[VALUE_WIDTH-2:0], qbit};
	assign ndig_next = (ndig_q < CNT_W'(DIGIT_BUFFER_DEPTH)) ? ndig_q + 1'b1 : ndig_q;
	assign pad_ext   = PADC_W'(pad_q);
	assign ndig_ext  = PADC_W'(ndig_next);
	assign rd_cnt    = ndig_q - 1'b1;
	assign rd_idx    = rd_cnt[IDX_W-1:0];
	assign load      = (state_q == S_EMIT) && (!out_valid_q || pop);
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				div_q   <= job.value;
				radix_q <= job.radix;
				pad_q   <= job.pad;
				part_q  <= '0;
			end
			S_DIV: begin
				div_q <= quot_next;
				if (step_q == '0) begin
					part_q <= '0;
					if (ndig_q < CNT_W'(DIGIT_BUFFER_DEPTH)) begin
						digit_q[ndig_q[IDX_W-1:0]] <= part_next;
					end
				end else begin
					part_q <= part_next;
				end
			end
			S_EMIT: begin
				if (load) begin
					if (pad_left_q != '0) begin
						out_q.character <= CHAR_ZERO;
						out_q.last      <= 1'b0;
					end else begin
						out_q.character <= digit_char(digit_q[rd_idx]);
						out_q.last      <= (ndig_q == CNT_W'(1));
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			ndig_q      <= '0;
			pad_left_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q && !load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						step_q  <= STEP_W'(VALUE_WIDTH - 1);
						ndig_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (step_q == '0) begin
						ndig_q <= ndig_next;
						step_q <= STEP_W'(VALUE_WIDTH - 1);
						if (quot_next == '0) begin
							pad_left_q <= (pad_ext > ndig_ext) ? pad_ext - ndig_ext : '0;
							state_q    <= S_EMIT;
						end
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				S_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						if (pad_left_q != '0) begin
							pad_left_q <= pad_left_q - 1'b1;
						end else begin
							ndig_q <= ndig_q - 1'b1;
							if (ndig_q == CNT_W'(1)) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/radix_number_to_ascii.sv =====
// ----------------------------------------------------------------------------
// radix_number_to_ascii
// Converts an unsigned number to ASCII digits in radix 8..36, zero padded.
// ----------------------------------------------------------------------------
// Each number yields D digits (1..22), one restoring-divider pass per digit;
//   the divider retires one quotient bit per cycle, and characters leave one
//   per cycle while the receiver pops.
// A two-entry job queue takes new numbers while a conversion runs.
// Reset clears queue pointers, engine state and the result valid flag; no memory sweep.
// ----------------------------------------------------------------------------
module radix_number_to_ascii import rnta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_beat_t  item,
	output logic      full,
	output logic      empty,
	input  logic      pop,
	output out_beat_t result
);

	logic q_full;
	logic q_push;
	logic q_valid;
	logic q_pop;
	job_t job_in;
	job_t job_out;

	rnta_front u_front (
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.full   (full),
		.q_push (q_push),
		.job    (job_in)
	);

	rnta_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.job_in  (job_in),
		.q_full  (q_full),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.job_out (job_out)
	);

	rnta_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.job     (job_out),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

`ifndef ASSERT_OFF
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("job queue popped while empty");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> q_valid) else $error("accepted beat missing from job queue");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result.character >= CHAR_ZERO && result.character <= CHAR_NINE)
			|| (result.character >= CHAR_A && result.character <= CHAR_Z)))
		else $error("result character outside digit set");
`endif

endmodule

// ===== sim/radix_ascii_checker.sv =====
// ----------------------------------------------------------------------------
// radix_ascii_checker
// Watches both queue ports of the radix number to ASCII converter. Each
// accepted number is spelled out into the characters it must produce, and
// each popped character is compared with the oldest one still due.
// ----------------------------------------------------------------------------
module radix_ascii_checker import rnta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_beat_t  item,
	input  logic      pop,
	input  logic      empty,
	input  out_beat_t result,
	output int        mismatch_count,
	output int        chars_waiting
);

	out_beat_t chars_due[$];
	out_beat_t want;

	initial begin
		mismatch_count = 0;
		chars_waiting  = 0;
	end

	function automatic void spell_number(input in_beat_t beat);
		logic [63:0] rest;
		logic [63:0] radix;
		int          pad;
		int          digit;
		logic [7:0]  digits[$];
		out_beat_t   ch;
		radix = 64'(beat.base);
		if (beat.base < RADIX_MIN) begin
			radix = 64'(RADIX_MIN);
		end
		if (beat.base > RADIX_MAX) begin
			radix = 64'(RADIX_MAX);
		end
		if (beat.pad_width > PAD_MAX) begin
			pad = int'(PAD_MAX);
		end else begin
			pad = int'(beat.pad_width);
		end
		rest = beat.value;
		do begin
			digit = int'(rest % radix);
			rest  = rest / radix;
			if (digit < 10) begin
				digits.push_front(CHAR_ZERO + 8'(digit));
			end else begin
				digits.push_front(CHAR_A + 8'(digit - 10));
			end
		end while (rest != 0);
		for (int k = digits.size(); k < pad; k++) begin
			ch.character = CHAR_ZERO;
			ch.last      = 1'b0;
			chars_due.push_back(ch);
		end
		foreach (digits[k]) begin
			ch.character = digits[k];
			ch.last      = (k == digits.size() - 1);
			chars_due.push_back(ch);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (chars_due.size() == 0) begin
					$error("unexpected character beat %h, last %b", result.character,
						result.last);
					mismatch_count++;
				end else begin
					want = chars_due.pop_front();
					if (result.character !== want.character) begin
						$error("character: expected %h, actual %h", want.character,
							result.character);
						mismatch_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %b, actual %b", want.last, result.last);
						mismatch_count++;
					end
				end
			end
			if (push && !full) begin
				spell_number(item);
			end
			chars_waiting = chars_due.size();
		end
	end

endmodule

// ===== sim/tb_radix_number_to_ascii.sv =====
// ----------------------------------------------------------------------------
// tb_radix_number_to_ascii
// Drives the converter with directed corner numbers and then random ones in
// three idling phases, with one long receiver hold-off that backs up the
// input queue. The checker beside the block reports the mismatch count.
// ----------------------------------------------------------------------------
module tb_radix_number_to_ascii;
	import rnta_pkg::*;

	localparam int HOLD_CYCLES      = 6000;
	localparam int CYCLE_LIMIT      = 1000000;
	localparam int TAIL_CYCLES      = 1500;
	localparam int RANDOM_PER_PHASE = 26;

	logic      clk;
	logic      arst_n;
	logic      push;
	in_beat_t  item;
	logic      full;
	logic      empty;
	logic      pop;
	out_beat_t result;

	int mismatch_count;
	int chars_waiting;
	int tx_idle_pct = 35;
	int rx_idle_pct = 60;
	int hold_reqs   = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int cycle_count = 0;

	radix_number_to_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	radix_ascii_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.item           (item),
		.pop            (pop),
		.empty          (empty),
		.result         (result),
		.mismatch_count (mismatch_count),
		.chars_waiting  (chars_waiting)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic in_beat_t random_number();
		in_beat_t b;
		b.value = {$urandom, $urandom} >> $urandom_range(0, 63);
		if ($urandom_range(0, 15) == 0) begin
			b.value = '0;
		end
		case ($urandom_range(0, 4))
			0: begin
				b.base = 6'd10;
			end
			1: begin
				b.base = 6'd16;
			end
			2, 3: begin
				b.base = 6'($urandom_range(8, 36));
			end
			default: begin
				b.base = 6'($urandom_range(0, 63));
			end
		endcase
		if ($urandom_range(0, 4) == 0) begin
			b.pad_width = 6'($urandom_range(0, 63));
		end else begin
			b.pad_width = 6'($urandom_range(0, 32));
		end
		return b;
	endfunction

	// call at a falling edge; returns at a falling edge with the beat taken
	task automatic send_number(input logic [63:0] v, input logic [5:0] b, input logic [5:0] p);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			item <= in_beat_t'({$urandom, $urandom, $urandom});
			@(negedge clk);
		end
		push           <= 1'b1;
		item.value     <= v;
		item.base      <= b;
		item.pad_width <= p;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		in_beat_t r;
		repeat (count) begin
			r = random_number();
			send_number(r.value, r.base, r.pad_width);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (chars_waiting != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_served != hold_reqs) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push   = 1'b0;
		item   = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_number(64'd0, 6'd10, 6'd0);
		send_number(64'd0, 6'd16, 6'd32);
		send_number('1, 6'd8, 6'd0);
		send_number('1, 6'd36, 6'd0);
		send_number('1, 6'd10, 6'd32);
		send_number('1, 6'd16, 6'd63);
		send_number(64'd12345, 6'd0, 6'd0);
		send_number(64'd12345, 6'd7, 6'd3);
		send_number(64'd12345, 6'd37, 6'd0);
		send_number(64'd12345, 6'd63, 6'd33);
		send_number(64'd35, 6'd36, 6'd0);
		send_number(64'd255, 6'd16, 6'd4);
		send_number(64'd1, 6'd10, 6'd1);
		send_number(64'd123456789, 6'd10, 6'd5);
		send_number(64'd9, 6'd10, 6'd0);
		send_number(64'd10, 6'd10, 6'd2);
		send_number(64'd10, 6'd11, 6'd0);
		send_number(64'h8000_0000_0000_0000, 6'd9, 6'd0);
		send_number(64'h5555_5555_5555_5555, 6'd11, 6'd21);
		send_number(64'haaaa_aaaa_aaaa_aaaa, 6'd13, 6'd42);
		send_number(64'd7, 6'd8, 6'd31);
		wait_drained();

		send_random(RANDOM_PER_PHASE);

		tx_idle_pct = 60;
		rx_idle_pct = 35;
		send_random(RANDOM_PER_PHASE);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_reqs++;
		send_random(RANDOM_PER_PHASE);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && chars_waiting == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
